FILE: hw/rtl/binarized_projection_minimum_finder_assert.svh
// assertion macros used by the projection minimum finder accumulate stage
`ifndef BINARIZED_PROJECTION_MINIMUM_FINDER_ASSERT_SVH
`define BINARIZED_PROJECTION_MINIMUM_FINDER_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define BPMF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bpmf assertion failed");

// condition that must never be true outside reset
`define BPMF_ASSERT_NEVER(label, clk, rst, cond) \
   `BPMF_ASSERT(label, clk, rst, !(cond))

`endif

FILE: hw/rtl/bpmf_pkg.sv
// shared types and constants of the projection minimum finder
package bpmf_pkg;

   localparam int unsigned PIX_W = 8;
   localparam int unsigned SUM_W = 16;
   localparam int unsigned BEST_W = SUM_W + 1;
   localparam int unsigned OUT_IDX_W = 8;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [BEST_W-1:0] BEST_INIT = '1;
   localparam logic [PIX_W-1:0] BIN_ONE = 8'd255;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd50;

   // register index decoded from the word address
   typedef enum logic {
      CSR_IDX_THRESHOLD = 1'b0,
      CSR_IDX_UNUSED = 1'b1
   } csr_idx_type;

   // input word
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic row_end;
      logic final_row;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [OUT_IDX_W-1:0] darkest_row;
      logic [SUM_W-1:0] darkest_row_sum;
      logic [OUT_IDX_W-1:0] darkest_col;
      logic [SUM_W-1:0] darkest_col_sum;
   } rsp_word_type;

   // control flags of one pixel between the front and accumulate stages
   typedef struct packed {
      logic bright;     // binarized value is 255
      logic row_end;
      logic final_row;
      logic first_row;  // pixel of row 0, column sum starts fresh
      logic col_ok;     // column lies inside the column store
      logic fwd_hit;    // column sum comes from the bypass, not the ram
   } slot_type;

endpackage

FILE: hw/rtl/bpmf_ram.sv
// generic single write port ram with registered read
module bpmf_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-cycle collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bpmf_csr.sv
// configuration register file holding the binarization threshold
module bpmf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bpmf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bpmf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bpmf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [bpmf_pkg::PIX_W-1:0]          threshold
);

   logic [bpmf_pkg::PIX_W-1:0] threshold_ff;
   logic [bpmf_pkg::PIX_W-1:0] threshold_in;
   bpmf_pkg::csr_idx_type reg_idx;
   logic wr_strobe;

   assign reg_idx = bpmf_pkg::csr_idx_type'(csr_paddr[bpmf_pkg::CSR_ADDR_W-1]);
   assign wr_strobe = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // write decode
   always_comb begin
      threshold_in = threshold_ff;
      unique case (reg_idx)
         bpmf_pkg::CSR_IDX_THRESHOLD: begin
            if (wr_strobe) begin
               threshold_in = csr_pwdata[bpmf_pkg::PIX_W-1:0];
            end
         end
         default: begin
            threshold_in = threshold_ff;
         end
      endcase
   end

   // read decode
   always_comb begin
      unique case (reg_idx)
         bpmf_pkg::CSR_IDX_THRESHOLD: csr_prdata = bpmf_pkg::CSR_DATA_W'(threshold_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= bpmf_pkg::THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign threshold = threshold_ff;

endmodule

FILE: hw/rtl/bpmf_front.sv
// input stage: pixel binarization, row and column counters, column sum read
module bpmf_front #(
   parameter int unsigned MAX_COLS = 256,
   parameter int unsigned MAX_ROWS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bpmf_pkg::req_word_type            req_word,
   input  logic [bpmf_pkg::PIX_W-1:0]        threshold,
   input  logic                              b_adv,
   input  logic                              wr_en,
   input  logic [$clog2(MAX_COLS)-1:0]       wr_addr,
   input  logic [bpmf_pkg::SUM_W-1:0]        wr_data,
   output logic                              rd_en,
   output logic [$clog2(MAX_COLS)-1:0]       rd_addr,
   output logic                              b_valid,
   output bpmf_pkg::slot_type                b_slot,
   output logic [$clog2(MAX_COLS)-1:0]       b_col,
   output logic [$clog2(MAX_ROWS)-1:0]       b_row,
   output logic [bpmf_pkg::SUM_W-1:0]        fwd_data
);

   localparam int unsigned COL_W = $clog2(MAX_COLS);
   localparam int unsigned CNT_W = $clog2(MAX_COLS + 1);
   localparam int unsigned ROW_W = $clog2(MAX_ROWS);
   localparam logic [CNT_W-1:0] COL_LIMIT = CNT_W'(MAX_COLS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

   logic [CNT_W-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic b_valid_ff, b_valid_in;
   bpmf_pkg::slot_type slot_ff, slot_in;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [bpmf_pkg::SUM_W-1:0] fwd_data_ff;
   logic accept;
   logic col_ok;

   assign req_stall = b_valid_ff && !b_adv;
   assign accept = req_valid && !req_stall;
   assign col_ok = col_cnt_ff < COL_LIMIT;

   // column sum read for the incoming pixel
   assign rd_en = accept;
   assign rd_addr = col_cnt_ff[COL_W-1:0];

   // flags of the incoming pixel
   always_comb begin
      slot_in.bright = req_word.pixel >= threshold;
      slot_in.row_end = req_word.row_end;
      slot_in.final_row = req_word.final_row;
      slot_in.first_row = row_cnt_ff == '0;
      slot_in.col_ok = col_ok;
      slot_in.fwd_hit = wr_en && (wr_addr == rd_addr);
   end

   // raster position counters
   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (req_word.row_end) begin
            col_cnt_in = '0;
            if (req_word.final_row) begin
               row_cnt_in = '0;
            end else if (row_cnt_ff < ROW_LAST) begin
               row_cnt_in = row_cnt_ff + 1'b1;
            end
         end else if (col_ok) begin
            col_cnt_in = col_cnt_ff + 1'b1;
         end
      end
   end

   // occupancy of the accumulate stage
   always_comb begin
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // pixel word register, bypass catches the sum written in the same cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= slot_in;
         col_ff <= rd_addr;
         row_ff <= row_cnt_ff;
         fwd_data_ff <= wr_data;
      end
   end

   assign b_valid = b_valid_ff;
   assign b_slot = slot_ff;
   assign b_col = col_ff;
   assign b_row = row_ff;
   assign fwd_data = fwd_data_ff;

endmodule

FILE: hw/rtl/bpmf_accum.sv
// accumulate stage: column and row sums, running minima and result register
`include "binarized_projection_minimum_finder_assert.svh"

module bpmf_accum #(
   parameter int unsigned MAX_COLS = 256,
   parameter int unsigned MAX_ROWS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              b_valid,
   input  bpmf_pkg::slot_type                b_slot,
   input  logic [$clog2(MAX_COLS)-1:0]       b_col,
   input  logic [$clog2(MAX_ROWS)-1:0]       b_row,
   input  logic [bpmf_pkg::SUM_W-1:0]        rd_data,
   input  logic [bpmf_pkg::SUM_W-1:0]        fwd_data,
   output logic                              b_adv,
   output logic                              wr_en,
   output logic [$clog2(MAX_COLS)-1:0]       wr_addr,
   output logic [bpmf_pkg::SUM_W-1:0]        wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bpmf_pkg::rsp_word_type            rsp_word
);

   localparam int unsigned COL_W = $clog2(MAX_COLS);
   localparam int unsigned ROW_W = $clog2(MAX_ROWS);
   localparam int unsigned SUM_W = bpmf_pkg::SUM_W;
   localparam int unsigned BEST_W = bpmf_pkg::BEST_W;
   localparam int unsigned OUT_W = bpmf_pkg::OUT_IDX_W;
   localparam int unsigned COL_X_W = (COL_W > OUT_W) ? COL_W : OUT_W;
   localparam int unsigned ROW_X_W = (ROW_W > OUT_W) ? ROW_W : OUT_W;

   logic [SUM_W-1:0] row_acc_ff, row_acc_in;
   logic [BEST_W-1:0] best_row_sum_ff, best_row_sum_in;
   logic [ROW_W-1:0] best_row_idx_ff, best_row_idx_in;
   logic [BEST_W-1:0] best_col_sum_ff, best_col_sum_in;
   logic [COL_W-1:0] best_col_idx_ff, best_col_idx_in;
   logic out_valid_ff, out_valid_in;
   bpmf_pkg::rsp_word_type out_word_ff;
   bpmf_pkg::rsp_word_type out_word_in;

   logic [SUM_W-1:0] bin_val;
   logic [SUM_W-1:0] col_base;
   logic [SUM_W:0] col_sum_wide;
   logic [SUM_W-1:0] col_sum;
   logic [SUM_W:0] row_sum_wide;
   logic [SUM_W-1:0] row_next;
   logic [BEST_W-1:0] col_best_nx, row_best_nx;
   logic [COL_W-1:0] col_idx_nx;
   logic [ROW_W-1:0] row_idx_nx;
   logic [COL_X_W-1:0] col_idx_x;
   logic [ROW_X_W-1:0] row_idx_x;
   logic win_end;
   logic out_free;

   // handshake between stage and result register
   assign win_end = b_slot.row_end && b_slot.final_row;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign b_adv = b_valid && (!win_end || out_free);

   // saturating column sum update
   always_comb begin
      bin_val = b_slot.bright ? SUM_W'(bpmf_pkg::BIN_ONE) : '0;
      col_base = b_slot.fwd_hit ? fwd_data : rd_data;
      col_sum_wide = {1'b0, col_base} + {1'b0, bin_val};
      if (b_slot.first_row) begin
         col_sum = bin_val;
      end else if (col_sum_wide[SUM_W]) begin
         col_sum = bpmf_pkg::SUM_MAX;
      end else begin
         col_sum = col_sum_wide[SUM_W-1:0];
      end
   end

   assign wr_en = b_adv && b_slot.col_ok;
   assign wr_addr = b_col;
   assign wr_data = col_sum;

   // saturating row sum
   always_comb begin
      row_sum_wide = {1'b0, row_acc_ff} + {1'b0, bin_val};
      if (!b_slot.col_ok) begin
         row_next = row_acc_ff;
      end else if (row_sum_wide[SUM_W]) begin
         row_next = bpmf_pkg::SUM_MAX;
      end else begin
         row_next = row_sum_wide[SUM_W-1:0];
      end
   end

   // first strict minimum over columns of the final row
   always_comb begin
      col_best_nx = best_col_sum_ff;
      col_idx_nx = best_col_idx_ff;
      if (b_slot.final_row && b_slot.col_ok && ({1'b0, col_sum} < best_col_sum_ff)) begin
         col_best_nx = {1'b0, col_sum};
         col_idx_nx = b_col;
      end
   end

   // first strict minimum over rows, checked at row end
   always_comb begin
      row_best_nx = best_row_sum_ff;
      row_idx_nx = best_row_idx_ff;
      if (b_slot.row_end && ({1'b0, row_next} < best_row_sum_ff)) begin
         row_best_nx = {1'b0, row_next};
         row_idx_nx = b_row;
      end
   end

   // result word, indices widened or cut to the output width
   always_comb begin
      col_idx_x = COL_X_W'(col_idx_nx);
      row_idx_x = ROW_X_W'(row_idx_nx);
      out_word_in.darkest_row = row_idx_x[OUT_W-1:0];
      out_word_in.darkest_row_sum = row_best_nx[SUM_W-1:0];
      out_word_in.darkest_col = col_idx_x[OUT_W-1:0];
      out_word_in.darkest_col_sum = col_best_nx[SUM_W-1:0];
   end

   // window state next values
   always_comb begin
      row_acc_in = row_acc_ff;
      best_row_sum_in = best_row_sum_ff;
      best_row_idx_in = best_row_idx_ff;
      best_col_sum_in = best_col_sum_ff;
      best_col_idx_in = best_col_idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (b_adv) begin
         row_acc_in = b_slot.row_end ? '0 : row_next;
         if (win_end) begin
            best_row_sum_in = bpmf_pkg::BEST_INIT;
            best_row_idx_in = '0;
            best_col_sum_in = bpmf_pkg::BEST_INIT;
            best_col_idx_in = '0;
            out_valid_in = 1'b1;
         end else begin
            best_row_sum_in = row_best_nx;
            best_row_idx_in = row_idx_nx;
            best_col_sum_in = col_best_nx;
            best_col_idx_in = col_idx_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_acc_ff <= '0;
         best_row_sum_ff <= bpmf_pkg::BEST_INIT;
         best_row_idx_ff <= '0;
         best_col_sum_ff <= bpmf_pkg::BEST_INIT;
         best_col_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         row_acc_ff <= row_acc_in;
         best_row_sum_ff <= best_row_sum_in;
         best_row_idx_ff <= best_row_idx_in;
         best_col_sum_ff <= best_col_sum_in;
         best_col_idx_ff <= best_col_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (b_adv && win_end) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_word_ff;

   // checks
   `BPMF_ASSERT_NEVER(a_no_result_overwrite, clock, reset,
      b_adv && win_end && out_valid_ff && rsp_stall)
   `BPMF_ASSERT(a_window_end_gives_result, clock, reset,
      b_adv && win_end |=> out_valid_ff)
   `BPMF_ASSERT(a_window_end_clears_minima, clock, reset,
      b_adv && win_end |=> best_row_sum_ff == bpmf_pkg::BEST_INIT
         && best_col_sum_ff == bpmf_pkg::BEST_INIT && row_acc_ff == '0)

endmodule

FILE: hw/rtl/binarized_projection_minimum_finder.sv
// Binarized projection minimum finder. Pixels of a window arrive in raster order,
// one word per clock; each is binarized against the threshold register (0 below,
// 255 otherwise) and summed per row and per column with saturation at 65535.
// The block reports the first row and the first column with the smallest sum in
// one result word, registered once the accumulate stage takes the pixel with both
// row_end and final_row. Throughput is one pixel per clock, set by the single
// column sum read-modify-write per pixel: the column store is a ram read in the
// input stage and written in the accumulate stage, with a bypass for back-to-back
// hits on one column. The input stalls only while a window-ending pixel waits
// for the result register to be taken. Column sums are not cleared at reset:
// row 0 of a window writes them fresh, so no clearing pass is needed. The
// threshold may be changed only while no window is in progress.
module binarized_projection_minimum_finder #(
   parameter int unsigned MAX_COLS = 256,
   parameter int unsigned MAX_ROWS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bpmf_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bpmf_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bpmf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bpmf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bpmf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned COL_W = $clog2(MAX_COLS);
   localparam int unsigned ROW_W = $clog2(MAX_ROWS);

   logic [bpmf_pkg::PIX_W-1:0] threshold;
   logic b_adv;
   logic b_valid;
   bpmf_pkg::slot_type b_slot;
   logic [COL_W-1:0] b_col;
   logic [ROW_W-1:0] b_row;
   logic wr_en;
   logic [COL_W-1:0] wr_addr;
   logic [bpmf_pkg::SUM_W-1:0] wr_data;
   logic rd_en;
   logic [COL_W-1:0] rd_addr;
   logic [bpmf_pkg::SUM_W-1:0] rd_data;
   logic [bpmf_pkg::SUM_W-1:0] fwd_data;

   // configuration registers
   bpmf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold)
   );

   // input stage
   bpmf_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .threshold (threshold),
      .b_adv     (b_adv),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .b_valid   (b_valid),
      .b_slot    (b_slot),
      .b_col     (b_col),
      .b_row     (b_row),
      .fwd_data  (fwd_data)
   );

   // column sum store
   bpmf_ram #(
      .WIDTH (bpmf_pkg::SUM_W),
      .DEPTH (MAX_COLS)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // accumulate stage and result register
   bpmf_accum #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .b_valid   (b_valid),
      .b_slot    (b_slot),
      .b_col     (b_col),
      .b_row     (b_row),
      .rd_data   (rd_data),
      .fwd_data  (fwd_data),
      .b_adv     (b_adv),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
